// ----- hw/rtl/frm_pkg.sv -----
package frm_pkg;

   localparam int MaxFlows = 16;
   localparam int SlotBits = 4;
   localparam int KeyBits = 32;
   localparam int WordBits = 32;
   localparam int AmountBits = 24;
   localparam int PeriodBits = 16;
   localparam logic [9:0] RateScale = 10'd1000;
   localparam logic [PeriodBits-1:0] PeriodReset = 16'd1000;
   localparam int QueueDepth = 2;

   typedef enum logic [2:0] {
      KIND_TRACK = 3'd0,
      KIND_UNTRACK = 3'd1,
      KIND_UPDATE = 3'd2,
      KIND_TICK = 3'd3,
      KIND_QUERY = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_TRACKED = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [KeyBits-1:0] flow_key;
      logic direction;
      logic [AmountBits-1:0] amount;
   } item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [WordBits-1:0] flow_rate;
      logic [WordBits-1:0] total_rate;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EXEC,
      ST_DIVIDE,
      ST_STORE,
      ST_EMIT
   } state_type;

endpackage

// ----- hw/rtl/frm_queue.sv -----
module frm_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input frm_pkg::item_type push_data,
   output logic full,
   input logic pop,
   output logic empty,
   output frm_pkg::item_type pop_data
);

   frm_pkg::item_type slot_ff [frm_pkg::QueueDepth];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/frm_divider.sv -----
module frm_divider (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [frm_pkg::WordBits-1:0] accum,
   input logic [frm_pkg::PeriodBits-1:0] period,
   output logic done,
   output logic [frm_pkg::WordBits-1:0] rate
);

   localparam int ProdBits = 42;

   logic [ProdBits-1:0] quot_ff, quot_in;
   logic [frm_pkg::PeriodBits:0] rem_ff, rem_in;
   logic [frm_pkg::PeriodBits-1:0] div_ff, div_in;
   logic [5:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [frm_pkg::PeriodBits+1:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = '0;
      if (start) begin
         quot_in = ProdBits'(accum) * ProdBits'(frm_pkg::RateScale);
         rem_in = '0;
         div_in = (period == '0) ? frm_pkg::PeriodBits'(1) : period;
         count_in = 6'(ProdBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quot_ff[ProdBits-1]} - {2'b00, div_ff};
         if (!trial[frm_pkg::PeriodBits+1]) begin
            rem_in = trial[frm_pkg::PeriodBits:0];
            quot_in = {quot_ff[ProdBits-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[frm_pkg::PeriodBits-1:0], quot_ff[ProdBits-1]};
            quot_in = {quot_ff[ProdBits-2:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign rate = (quot_ff[ProdBits-1:frm_pkg::WordBits] != '0) ? '1
      : quot_ff[frm_pkg::WordBits-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

// ----- hw/rtl/frm_engine.sv -----
module frm_engine (
   input logic clock,
   input logic reset,
   input logic [frm_pkg::PeriodBits-1:0] period,
   input logic cmd_empty,
   input frm_pkg::item_type cmd,
   output logic cmd_pop,
   input logic rsp_pop,
   output logic rsp_empty,
   output frm_pkg::result_type rsp
);

   localparam int SB = frm_pkg::SlotBits;
   localparam int WB = frm_pkg::WordBits;

   logic [frm_pkg::KeyBits-1:0] key_ff [frm_pkg::MaxFlows];
   logic [frm_pkg::MaxFlows-1:0] valid_ff, valid_in;
   logic [WB-1:0] in_acc_ff [frm_pkg::MaxFlows];
   logic [WB-1:0] out_acc_ff [frm_pkg::MaxFlows];
   logic [WB-1:0] in_rate_ff [frm_pkg::MaxFlows];
   logic [WB-1:0] out_rate_ff [frm_pkg::MaxFlows];
   logic [WB-1:0] tot_acc_ff [2];
   logic [WB-1:0] tot_rate_ff [2];

   frm_pkg::state_type state_ff, state_in;
   frm_pkg::item_type item_ff;
   frm_pkg::result_type res_ff, res_in;
   logic hit_ff, free_ff;
   logic [SB-1:0] hit_slot_ff, free_slot_ff;
   logic hit_c, free_c;
   logic [SB-1:0] hit_slot_c, free_slot_c;
   logic [SB:0] walk_ff, walk_in;
   logic walk_dir_ff, walk_dir_in;
   logic div_start;
   logic div_done;
   logic [WB-1:0] div_accum, div_rate;
   logic [WB:0] sum;
   logic [WB-1:0] sat_sum, cur_acc;
   logic walk_total;

   always_comb begin
      hit_c = 1'b0;
      hit_slot_c = '0;
      free_c = 1'b0;
      free_slot_c = '0;
      for (int i = frm_pkg::MaxFlows - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == item_ff.flow_key) begin
            hit_c = 1'b1;
            hit_slot_c = SB'(i);
         end
         if (!valid_ff[i]) begin
            free_c = 1'b1;
            free_slot_c = SB'(i);
         end
      end
   end

   assign walk_total = walk_ff[SB];
   assign cur_acc = item_ff.direction ? out_acc_ff[hit_slot_ff] : in_acc_ff[hit_slot_ff];
   assign div_accum = walk_in[SB] ? tot_acc_ff[walk_dir_in]
      : (walk_dir_in ? out_acc_ff[walk_in[SB-1:0]] : in_acc_ff[walk_in[SB-1:0]]);
   assign cmd_pop = (state_ff == frm_pkg::ST_IDLE) && !cmd_empty;
   assign rsp_empty = (state_ff != frm_pkg::ST_EMIT);
   assign rsp = res_ff;

   frm_divider u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .accum(div_accum),
      .period(period),
      .done(div_done),
      .rate(div_rate)
   );

   always_comb begin
      state_in = state_ff;
      res_in = res_ff;
      walk_in = walk_ff;
      walk_dir_in = walk_dir_ff;
      div_start = 1'b0;
      valid_in = valid_ff;
      sum = '0;
      sat_sum = '0;
      unique case (state_ff)
         frm_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               state_in = frm_pkg::ST_LOOKUP;
            end
         end
         frm_pkg::ST_LOOKUP: begin
            state_in = frm_pkg::ST_EXEC;
         end
         frm_pkg::ST_EXEC: begin
            res_in = '0;
            state_in = frm_pkg::ST_EMIT;
            case (item_ff.kind)
               frm_pkg::KIND_TRACK: begin
                  if (hit_ff) begin
                     res_in.status = frm_pkg::STATUS_TRACKED;
                  end else if (!free_ff) begin
                     res_in.status = frm_pkg::STATUS_FULL;
                  end else begin
                     valid_in[free_slot_ff] = 1'b1;
                  end
               end
               frm_pkg::KIND_UNTRACK: begin
                  if (!hit_ff) begin
                     res_in.status = frm_pkg::STATUS_NOT_FOUND;
                  end else begin
                     valid_in[hit_slot_ff] = 1'b0;
                  end
               end
               frm_pkg::KIND_UPDATE: begin
                  if (!hit_ff) begin
                     res_in.status = frm_pkg::STATUS_NOT_FOUND;
                  end
               end
               frm_pkg::KIND_TICK: begin
                  walk_in = '0;
                  walk_dir_in = 1'b0;
                  div_start = 1'b1;
                  state_in = frm_pkg::ST_DIVIDE;
               end
               frm_pkg::KIND_QUERY: begin
                  if (!hit_ff) begin
                     res_in.status = frm_pkg::STATUS_NOT_FOUND;
                  end else begin
                     res_in.flow_rate = item_ff.direction ? out_rate_ff[hit_slot_ff]
                        : in_rate_ff[hit_slot_ff];
                  end
                  res_in.total_rate = tot_rate_ff[item_ff.direction];
               end
               default: begin
               end
            endcase
         end
         frm_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = frm_pkg::ST_STORE;
            end
         end
         frm_pkg::ST_STORE: begin
            if (walk_total && walk_dir_ff) begin
               state_in = frm_pkg::ST_EMIT;
            end else begin
               walk_dir_in = !walk_dir_ff;
               if (walk_dir_ff) begin
                  walk_in = walk_ff + 1'b1;
               end
               div_start = 1'b1;
               state_in = frm_pkg::ST_DIVIDE;
            end
         end
         frm_pkg::ST_EMIT: begin
            if (rsp_pop) begin
               state_in = frm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frm_pkg::ST_IDLE;
         end
      endcase
      sum = {1'b0, cur_acc} + {9'd0, item_ff.amount};
      sat_sum = sum[WB] ? '1 : sum[WB-1:0];
   end

   logic [WB:0] tsum;
   logic [WB-1:0] tsat;
   assign tsum = {1'b0, tot_acc_ff[item_ff.direction]} + {9'd0, item_ff.amount};
   assign tsat = tsum[WB] ? '1 : tsum[WB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frm_pkg::ST_IDLE;
         valid_ff <= '0;
         tot_acc_ff[0] <= '0;
         tot_acc_ff[1] <= '0;
         tot_rate_ff[0] <= '0;
         tot_rate_ff[1] <= '0;
         for (int i = 0; i < frm_pkg::MaxFlows; i++) begin
            in_acc_ff[i] <= '0;
            out_acc_ff[i] <= '0;
            in_rate_ff[i] <= '0;
            out_rate_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (state_ff == frm_pkg::ST_EXEC) begin
            case (item_ff.kind)
               frm_pkg::KIND_TRACK: begin
                  if (!hit_ff && free_ff) begin
                     key_ff[free_slot_ff] <= item_ff.flow_key;
                     in_acc_ff[free_slot_ff] <= '0;
                     out_acc_ff[free_slot_ff] <= '0;
                     in_rate_ff[free_slot_ff] <= '0;
                     out_rate_ff[free_slot_ff] <= '0;
                  end
               end
               frm_pkg::KIND_UNTRACK: begin
                  if (hit_ff) begin
                     in_acc_ff[hit_slot_ff] <= '0;
                     out_acc_ff[hit_slot_ff] <= '0;
                     in_rate_ff[hit_slot_ff] <= '0;
                     out_rate_ff[hit_slot_ff] <= '0;
                  end
               end
               frm_pkg::KIND_UPDATE: begin
                  if (hit_ff) begin
                     if (item_ff.direction) begin
                        out_acc_ff[hit_slot_ff] <= sat_sum;
                     end else begin
                        in_acc_ff[hit_slot_ff] <= sat_sum;
                     end
                  end
                  tot_acc_ff[item_ff.direction] <= tsat;
               end
               default: begin
               end
            endcase
         end
         if (state_ff == frm_pkg::ST_STORE) begin
            if (walk_total) begin
               tot_rate_ff[walk_dir_ff] <= div_rate;
               tot_acc_ff[walk_dir_ff] <= '0;
            end else if (walk_dir_ff) begin
               if (valid_ff[walk_ff[SB-1:0]]) begin
                  out_rate_ff[walk_ff[SB-1:0]] <= div_rate;
               end
               out_acc_ff[walk_ff[SB-1:0]] <= '0;
            end else begin
               if (valid_ff[walk_ff[SB-1:0]]) begin
                  in_rate_ff[walk_ff[SB-1:0]] <= div_rate;
               end
               in_acc_ff[walk_ff[SB-1:0]] <= '0;
            end
         end
      end
      if (cmd_pop) begin
         item_ff <= cmd;
      end
      if (state_ff == frm_pkg::ST_LOOKUP) begin
         hit_ff <= hit_c;
         hit_slot_ff <= hit_slot_c;
         free_ff <= free_c;
         free_slot_ff <= free_slot_c;
      end
      res_ff <= res_in;
      walk_ff <= walk_in;
      walk_dir_ff <= walk_dir_in;
   end

endmodule

// ----- hw/rtl/flow_rate_meter_table.sv -----
// Channel   Direction   Handshake        Payload
// req       in          push / full      kind, flow_key, direction, amount
// rsp       out         pop / empty      status, flow_rate, total_rate
// csr       in          write enable     sample_ms
// Track, untrack, update and query each pass through the idle, lookup, exec and emit states of the table engine.
// A tick divides 34 accumulators in turn, using one shared divider.
// Reset is synchronous and clears all valid bits, accumulators and rates.
// Items wait in a two-entry queue while the engine is busy or its result is not taken.
module flow_rate_meter_table (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input logic [2:0] req_kind,
   input logic [31:0] req_flow_key,
   input logic req_direction,
   input logic [23:0] req_amount,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic [1:0] rsp_status,
   output logic [31:0] rsp_flow_rate,
   output logic [31:0] rsp_total_rate,
   input logic csr_we,
   input logic [15:0] csr_wdata
);

   logic [frm_pkg::PeriodBits-1:0] period_ff;
   frm_pkg::item_type req_item, cmd;
   frm_pkg::result_type res;
   logic cmd_empty, cmd_pop;

   assign req_item = '{kind: req_kind, flow_key: req_flow_key,
      direction: req_direction, amount: req_amount};

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= frm_pkg::PeriodReset;
      end else if (csr_we) begin
         period_ff <= csr_wdata;
      end
   end

   frm_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .push_data(req_item),
      .full(req_full),
      .pop(cmd_pop),
      .empty(cmd_empty),
      .pop_data(cmd)
   );

   frm_engine u_engine (
      .clock(clock),
      .reset(reset),
      .period(period_ff),
      .cmd_empty(cmd_empty),
      .cmd(cmd),
      .cmd_pop(cmd_pop),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp(res)
   );

   assign rsp_status = res.status;
   assign rsp_flow_rate = res.flow_rate;
   assign rsp_total_rate = res.total_rate;

endmodule
